[rtl/sbs_pkg.sv]
// Shared types, constants and arithmetic helpers for the spectrum bar smoother.
`default_nettype none
package sbs_pkg;

	localparam int NUM_BANDS   = 9;
	localparam int NUM_BARS    = 17;
	localparam int LEVEL_W     = 7;
	localparam int BAND_IDX_W  = $clog2(NUM_BANDS);
	localparam int BAR_IDX_W   = 5;

	localparam int IN_MAX       = 100;
	localparam int CENTRE_BASE  = 28;
	localparam int CENTRE_SPAN  = 72;
	localparam int MIX_STABLE   = 82;
	localparam int MIX_SPECTRAL = 18;
	localparam int MIX_BASE     = 215;
	localparam int MIX_STEP     = 14;
	localparam int MIX_GAIN     = 40;
	localparam int MAX_HEIGHT   = 34;
	localparam int MIN_HEIGHT   = 3;
	localparam int CANVAS_W     = 236;
	localparam int CANVAS_H     = 44;
	localparam int BAR_W        = 6;
	localparam int BAR_GAP      = 5;
	localparam int BAR_PITCH    = BAR_W + BAR_GAP;
	localparam int START_X      = (CANVAS_W - (NUM_BARS * BAR_W + (NUM_BARS - 1) * BAR_GAP)) / 2;
	localparam int CENTRE_BAR   = (NUM_BARS - 1) / 2;

	// Pipeline over the bands is three stages deep; the last band leaves it at this count.
	localparam int RUN_LAST     = NUM_BANDS + 2;
	localparam int RUN_CNT_W    = $clog2(RUN_LAST + 1);

	localparam int QUEUE_DEPTH  = 2;

	localparam logic [LEVEL_W-1:0] ENVELOPE [NUM_BANDS] = '{
		7'd100, 7'd91, 7'd82, 7'd73, 7'd64, 7'd55, 7'd46, 7'd37, 7'd28
	};

	typedef struct packed {
		logic [6:0] band_0;
		logic [6:0] band_1;
		logic [6:0] band_2;
		logic [6:0] band_3;
		logic [6:0] band_4;
		logic [6:0] band_5;
		logic [6:0] band_6;
		logic [6:0] band_7;
		logic [6:0] band_8;
		logic [6:0] overall_level;
	} in_t;

	typedef struct packed {
		logic [4:0] bar_index;
		logic [7:0] x_left;
		logic [4:0] y_top;
		logic [5:0] bar_height;
		logic [7:0] mix_weight;
		logic       last_bar;
	} out_t;

	typedef logic [NUM_BANDS-1:0][LEVEL_W-1:0] levels_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_ENERGY,
		F_CENTRE,
		F_RUN,
		F_PUSH
	} front_state_t;

	function automatic logic [6:0] sat_in(input logic [6:0] v);
		return (v > 7'(IN_MAX)) ? 7'(IN_MAX) : v;
	endfunction

	// Exact for every 14-bit operand: reciprocal of 100 scaled by 2^24, rounded up.
	function automatic logic [7:0] div100(input logic [13:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'd167773;
		return p[31:24];
	endfunction

	// Exact for every 9-bit operand: reciprocal of 5 scaled by 2^12, rounded up.
	function automatic logic [6:0] div5(input logic [8:0] x);
		logic [18:0] p;
		p = 19'(x) * 19'd820;
		return p[18:12];
	endfunction

	// Exact for operands below 384: reciprocal of 3 scaled by 2^12, rounded up.
	function automatic logic [6:0] div3(input logic [8:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd1366;
		return p[18:12];
	endfunction

	// Levels rise fast toward a higher target and fall slowly toward a lower one.
	function automatic logic [6:0] smooth(input logic [6:0] cur, input logic [6:0] tgt);
		logic [9:0] fall;
		fall = 10'(cur) * 10'd7 + 10'(tgt);
		if (tgt > cur) begin
			return div3(9'(cur) + {1'b0, tgt, 1'b0});
		end
		return fall[9:3];
	endfunction

endpackage
`default_nettype wire

[rtl/sbs_queue.sv]
// Two-entry request queue that carries smoothed level snapshots from front to back.
`default_nettype none
module sbs_queue
	import sbs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_valid,
	output logic         wr_ready,
	input  wire levels_t wr_data,
	output logic         rd_valid,
	input  wire logic    rd_ready,
	output levels_t      rd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	levels_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

[rtl/sbs_front.sv]
// Front end: takes a frame, derives the band targets and updates the smoothed levels.
`default_nettype none
module sbs_front
	import sbs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire in_t  item,
	output logic      push_valid,
	input  wire logic push_ready,
	output levels_t   push_levels
);

	front_state_t           state_q;
	front_state_t           state_d;

	logic [6:0]             band_q [NUM_BANDS];
	logic [6:0]             lvl_q;
	logic [6:0]             energy_q;
	logic                   active_q;
	logic [6:0]             tgt0_q;
	logic [RUN_CNT_W-1:0]   cnt_q;
	levels_t                levels_q;

	logic                   v_s1;
	logic [BAND_IDX_W-1:0]  k_s1;
	logic [6:0]             shaped_s1;
	logic                   v_s2;
	logic [BAND_IDX_W-1:0]  k_s2;
	logic [13:0]            prod_s2;
	logic                   v_s3;
	logic [BAND_IDX_W-1:0]  k_s3;
	logic [6:0]             tgt_s3;

	logic                   accept;
	logic [9:0]             low_sum;
	logic [6:0]             low_mid;
	logic [8:0]             energy_sum;
	logic                   any_band;
	logic                   issue;
	logic [BAND_IDX_W-1:0]  k_issue;
	logic [BAND_IDX_W-1:0]  spec_idx;
	logic [7:0]             pair_sum;
	logic [6:0]             spec;
	logic [13:0]            mix_sum;
	logic [6:0]             t_val;
	logic [6:0]             lim;

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			F_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = F_ENERGY;
				end
			end
			F_ENERGY: state_d = F_CENTRE;
			F_CENTRE: state_d = F_RUN;
			F_RUN: begin
				if (cnt_q == RUN_CNT_W'(RUN_LAST)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign push_levels = levels_q;

	always_comb begin
		low_sum    = 10'(band_q[0]) * 10'd3 + 10'(band_q[1]) * 10'd2
			+ 10'(band_q[2]) * 10'd2 + 10'(band_q[3]);
		low_mid    = low_sum[9:3];
		energy_sum = 9'(lvl_q) * 9'd3 + 9'(low_mid) * 9'd2;
		any_band   = 1'b0;
		for (int i = 0; i < NUM_BANDS; i++) begin
			any_band = any_band | (band_q[i] != '0);
		end
	end

	always_comb begin
		issue    = (state_q == F_RUN) && (cnt_q < RUN_CNT_W'(NUM_BANDS));
		k_issue  = cnt_q[BAND_IDX_W-1:0];
		spec_idx = (k_issue == '0) ? '0 : k_issue - 1'b1;
		pair_sum = 8'(band_q[NUM_BANDS-2]) + 8'(band_q[NUM_BANDS-1]);
		spec     = (k_issue == BAND_IDX_W'(NUM_BANDS - 1)) ? pair_sum[7:1] : band_q[spec_idx];
		mix_sum  = 14'(tgt0_q) * 14'(MIX_STABLE) + 14'(spec) * 14'(MIX_SPECTRAL);
		t_val    = 7'(div100(prod_s2));
		lim      = (tgt_s3 > 7'd2) ? tgt_s3 - 7'd2 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			levels_q <= '0;
		end else begin
			if (state_q == F_CENTRE) begin
				cnt_q <= '0;
			end else if (state_q == F_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				levels_q[k_s3] <= smooth(levels_q[k_s3], tgt_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			band_q[0] <= sat_in(item.band_0);
			band_q[1] <= sat_in(item.band_1);
			band_q[2] <= sat_in(item.band_2);
			band_q[3] <= sat_in(item.band_3);
			band_q[4] <= sat_in(item.band_4);
			band_q[5] <= sat_in(item.band_5);
			band_q[6] <= sat_in(item.band_6);
			band_q[7] <= sat_in(item.band_7);
			band_q[8] <= sat_in(item.band_8);
			lvl_q     <= sat_in(item.overall_level);
		end
		if (state_q == F_ENERGY) begin
			energy_q <= div5(energy_sum);
			active_q <= (energy_sum > 9'd4) || any_band;
		end
		if (state_q == F_CENTRE) begin
			tgt0_q <= active_q ?
				7'(CENTRE_BASE) + 7'(div100(14'(energy_q) * 14'(CENTRE_SPAN))) : '0;
		end
		k_s1      <= k_issue;
		shaped_s1 <= 7'(div100(mix_sum));
		k_s2      <= k_s1;
		prod_s2   <= 14'(shaped_s1) * 14'(ENVELOPE[k_s1]);
		if (v_s2) begin
			k_s3   <= k_s2;
			tgt_s3 <= (k_s2 == '0) ? tgt0_q : ((t_val > lim) ? lim : t_val);
		end
	end

endmodule
`default_nettype wire

[rtl/sbs_back.sv]
// Back end: turns one level snapshot into seventeen mirrored bar requests.
`default_nettype none
module sbs_back
	import sbs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pop_valid,
	output logic         pop_ready,
	input  wire levels_t pop_levels,
	output logic         bar_valid,
	input  wire logic    bar_ready,
	output out_t         bar
);

	logic                   busy_q;
	logic [BAR_IDX_W-1:0]   bar_q;
	levels_t                frame_q;
	out_t                   out_q;
	logic                   out_v_q;

	logic                   adv;
	logic                   last;
	logic [BAND_IDX_W-1:0]  dist_idx;
	logic [6:0]             v;
	logic [5:0]             h;
	logic [8:0]             mix;
	logic [5:0]             gap;
	out_t                   nxt;

	assign bar_valid = out_v_q;
	assign bar       = out_q;
	assign adv       = busy_q && (!out_v_q || bar_ready);
	assign last      = (bar_q == BAR_IDX_W'(NUM_BARS - 1));
	assign pop_ready = !busy_q || (adv && last);

	always_comb begin
		dist_idx = (bar_q < BAR_IDX_W'(CENTRE_BAR)) ?
			BAND_IDX_W'(BAR_IDX_W'(CENTRE_BAR) - bar_q) :
			BAND_IDX_W'(bar_q - BAR_IDX_W'(CENTRE_BAR));
		v    = frame_q[dist_idx];
		h    = 6'(MIN_HEIGHT) + 6'(div100(14'(v) * 14'(MAX_HEIGHT - MIN_HEIGHT)));
		mix  = 9'(MIX_BASE) - 9'(dist_idx) * 9'(MIX_STEP)
			+ 9'(div100(14'(v) * 14'(MIX_GAIN)));
		gap  = 6'(CANVAS_H) - h;
		nxt.bar_index  = bar_q;
		nxt.x_left     = 8'(START_X) + 8'(bar_q) * 8'(BAR_PITCH);
		nxt.y_top      = gap[5:1];
		nxt.bar_height = h;
		nxt.mix_weight = (mix > 9'd255) ? 8'd255 : mix[7:0];
		nxt.last_bar   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			bar_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (bar_ready) begin
				out_v_q <= 1'b0;
			end
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				bar_q  <= '0;
			end else if (adv) begin
				bar_q <= bar_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			frame_q <= pop_levels;
		end
		if (adv) begin
			out_q <= nxt;
		end
	end

endmodule
`default_nettype wire

[rtl/spectrum_bar_smoother.sv]
// Top level of the spectrum bar smoother: front end, snapshot queue and bar generator.
// The front end takes a new frame only after it has pushed the last snapshot to the queue;
// it runs a three-stage band pipeline nine times per frame, once per band.
// The back end emits one bar per cycle while the bar side does not stall, seventeen bars a frame.
// The queue lets the front end work on the next frame while the back end emits bars.
// Reset clears the nine smoothed levels to zero and empties the queue.
`default_nettype none
module spectrum_bar_smoother
	import sbs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire in_t  item,
	output logic      bar_valid,
	input  wire logic bar_ready,
	output out_t      bar
);

	logic    push_valid;
	logic    push_ready;
	levels_t push_levels;
	logic    pop_valid;
	logic    pop_ready;
	levels_t pop_levels;

	sbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_levels (push_levels)
	);

	sbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_levels),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_levels)
	);

	sbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_levels (pop_levels),
		.bar_valid  (bar_valid),
		.bar_ready  (bar_ready),
		.bar        (bar)
	);

endmodule
`default_nettype wire

[rtl/sbs_checker.sv]
// Port-level checks for the spectrum bar smoother and their binding to the top level.
`default_nettype none
module sbs_checker
	import sbs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic bar_valid,
	input wire logic bar_ready,
	input wire out_t bar
);

	// A stalled bar request must hold its contents.
	a_bar_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && !bar_ready |=> bar_valid && $stable(bar))
		else $error("bar request changed while stalled");

	// The last-bar flag marks exactly the final bar of a frame.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid |-> (bar.last_bar == (bar.bar_index == 5'(NUM_BARS - 1))))
		else $error("last_bar does not match bar_index");

	// Bars of one frame follow each other without gaps once one has been taken.
	a_bar_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_ready && !bar.last_bar
		|=> bar_valid && (bar.bar_index == $past(bar.bar_index) + 5'd1))
		else $error("bar sequence broken within a frame");

	// The top row centers the bar vertically on the canvas.
	a_bar_centred: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid |-> (6'(bar.y_top) == ((6'(CANVAS_H) - bar.bar_height) >> 1)))
		else $error("y_top inconsistent with bar_height");

	// Heights stay within the drawable band.
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid |-> (bar.bar_height >= 6'(MIN_HEIGHT)) && (bar.bar_height <= 6'(MAX_HEIGHT)))
		else $error("bar_height out of range");

endmodule

bind spectrum_bar_smoother sbs_checker u_sbs_checker (.*);
`default_nettype wire

[verif/tb_spectrum_bar_smoother.sv]
// Self-checking testbench for the spectrum bar smoother, with directed and random frames.
`default_nettype none
module tb_spectrum_bar_smoother;
	import sbs_pkg::*;

	localparam int RANDOM_FRAMES = 150;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 40;

	localparam out_t CENTRE_SILENT = '{bar_index: 5'd8, x_left: 8'd115, y_top: 5'd20,
		bar_height: 6'd3, mix_weight: 8'd215, last_bar: 1'b0};
	localparam out_t CENTRE_FULL = '{bar_index: 5'd8, x_left: 8'd115, y_top: 5'd10,
		bar_height: 6'd23, mix_weight: 8'd241, last_bar: 1'b0};
	localparam out_t NO_PIN = '0;

	typedef struct packed {
		in_t  frame;
		logic pinned;
		out_t centre;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_t  item = '0;
	logic bar_valid;
	logic bar_ready = 1'b0;
	out_t bar;

	logic [6:0] level_mem [NUM_BANDS];
	out_t pending_bars [$];
	row_t dir_rows [$];
	bit   calm = 1'b0;
	int   errors = 0;
	int   frames_sent = 0;
	int   bars_seen = 0;
	int   cycle_count = 0;

	spectrum_bar_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.bar_valid (bar_valid),
		.bar_ready (bar_ready),
		.bar       (bar)
	);

	always #1 clk = ~clk;

	function automatic in_t frame_of(input int b0, input int b1, input int b2, input int b3,
		input int b4, input int b5, input int b6, input int b7, input int b8, input int ovl);
		in_t f;
		f.band_0 = 7'(b0);
		f.band_1 = 7'(b1);
		f.band_2 = 7'(b2);
		f.band_3 = 7'(b3);
		f.band_4 = 7'(b4);
		f.band_5 = 7'(b5);
		f.band_6 = 7'(b6);
		f.band_7 = 7'(b7);
		f.band_8 = 7'(b8);
		f.overall_level = 7'(ovl);
		return f;
	endfunction

	function automatic int clip_level(input logic [6:0] v);
		return (v > IN_MAX) ? IN_MAX : int'(v);
	endfunction

	function automatic void smooth_frame(input in_t f);
		int b [NUM_BANDS];
		int tgt [NUM_BANDS];
		int ovl, low_mid, energy, spec, shaped, t, lim, cur, d, v, h, mix;
		bit active;
		out_t o;
		b[0] = clip_level(f.band_0);
		b[1] = clip_level(f.band_1);
		b[2] = clip_level(f.band_2);
		b[3] = clip_level(f.band_3);
		b[4] = clip_level(f.band_4);
		b[5] = clip_level(f.band_5);
		b[6] = clip_level(f.band_6);
		b[7] = clip_level(f.band_7);
		b[8] = clip_level(f.band_8);
		ovl = clip_level(f.overall_level);
		low_mid = (b[0] * 3 + b[1] * 2 + b[2] * 2 + b[3]) / 8;
		energy = (ovl * 3 + low_mid * 2) / 5;
		active = energy > 0;
		foreach (b[k]) begin
			if (b[k] > 0) active = 1'b1;
		end
		tgt[0] = active ? CENTRE_BASE + energy * CENTRE_SPAN / 100 : 0;
		for (int k = 1; k < NUM_BANDS; k++) begin
			spec = (k == NUM_BANDS - 1) ? (b[7] + b[8]) / 2 : b[k - 1];
			shaped = (tgt[0] * MIX_STABLE + spec * MIX_SPECTRAL) / 100;
			t = shaped * int'(ENVELOPE[k]) / 100;
			lim = (tgt[k - 1] > 2) ? tgt[k - 1] - 2 : 0;
			tgt[k] = (t > lim) ? lim : t;
		end
		for (int k = 0; k < NUM_BANDS; k++) begin
			cur = level_mem[k];
			level_mem[k] = 7'((tgt[k] > cur) ? (cur + tgt[k] * 2) / 3 : (cur * 7 + tgt[k]) / 8);
		end
		for (int k = 0; k < NUM_BARS; k++) begin
			d = (k < CENTRE_BAR) ? CENTRE_BAR - k : k - CENTRE_BAR;
			v = level_mem[d];
			h = MIN_HEIGHT + v * (MAX_HEIGHT - MIN_HEIGHT) / 100;
			mix = MIX_BASE - d * MIX_STEP + v * MIX_GAIN / 100;
			if (mix > 255) mix = 255;
			o.bar_index = 5'(k);
			o.x_left = 8'(START_X + k * BAR_PITCH);
			o.y_top = 5'((CANVAS_H - h) / 2);
			o.bar_height = 6'(h);
			o.mix_weight = 8'(mix);
			o.last_bar = (k == NUM_BARS - 1);
			pending_bars.push_back(o);
		end
	endfunction

	task automatic note_error(input string what, input out_t want, input out_t got);
		errors++;
		if (errors <= 10) begin
			$display("%s at cycle %0d: expected idx=%0d x=%0d y=%0d h=%0d mix=%0d last=%0b",
				what, cycle_count, want.bar_index, want.x_left, want.y_top, want.bar_height,
				want.mix_weight, want.last_bar);
			$display("    got idx=%0d x=%0d y=%0d h=%0d mix=%0d last=%0b",
				got.bar_index, got.x_left, got.y_top, got.bar_height, got.mix_weight,
				got.last_bar);
		end
	endtask

	task automatic send_frame(input in_t f, input logic pinned, input out_t centre);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= f;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		smooth_frame(f);
		if (pinned) begin
			pending_bars[pending_bars.size() - NUM_BARS + CENTRE_BAR] = centre;
		end
		frames_sent++;
	endtask

	task automatic drain_wait();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_bars.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d bars outstanding.",
				cycle_count, pending_bars.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin : check_bars
		out_t want;
		if (arst_n && bar_valid && bar_ready) begin
			bars_seen++;
			if (pending_bars.size() == 0) begin
				note_error("Unexpected bar", NO_PIN, bar);
			end else begin
				want = pending_bars.pop_front();
				if (bar.bar_index !== want.bar_index || bar.x_left !== want.x_left ||
						bar.y_top !== want.y_top || bar.bar_height !== want.bar_height ||
						bar.mix_weight !== want.mix_weight || bar.last_bar !== want.last_bar) begin
					note_error("Bar mismatch", want, bar);
				end
			end
		end
	end

	initial begin : bar_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				bar_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			bar_ready <= 1'b1;
			@(posedge clk);
			while (!bar_valid) @(posedge clk);
		end
	end

	initial begin : frame_source
		in_t f;
		int kind;
		int n_dir;
		foreach (level_mem[k]) level_mem[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, CENTRE_SILENT});
		dir_rows.push_back({frame_of(127, 127, 127, 127, 127, 127, 127, 127, 127, 127),
			1'b1, CENTRE_FULL});
		dir_rows.push_back({frame_of(100, 100, 100, 100, 100, 100, 100, 100, 100, 100),
			1'b0, NO_PIN});
		dir_rows.push_back({frame_of(101, 101, 101, 101, 101, 101, 101, 101, 101, 101),
			1'b0, NO_PIN});
		dir_rows.push_back({frame_of(85, 85, 85, 85, 85, 85, 85, 85, 85, 85), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(42, 42, 42, 42, 42, 42, 42, 42, 42, 42), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 100), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(100, 100, 100, 100, 100, 100, 100, 100, 100, 0),
			1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 100, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(127, 0, 127, 0, 127, 0, 127, 0, 127, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(1, 1, 1, 1, 1, 1, 1, 1, 1, 1), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(0, 0, 0, 1, 0, 0, 0, 0, 0, 2), 1'b0, NO_PIN});
		dir_rows.push_back({frame_of(127, 127, 127, 127, 127, 127, 127, 127, 127, 127),
			1'b0, NO_PIN});

		foreach (dir_rows[r]) begin
			send_frame(dir_rows[r].frame, dir_rows[r].pinned, dir_rows[r].centre);
		end
		n_dir = frames_sent;
		drain_wait();

		for (int i = 0; i < RANDOM_FRAMES; i++) begin
			if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i == 60 || i == 120) drain_wait();
			kind = $urandom_range(0, 9);
			f = '0;
			for (int j = 0; j < NUM_BANDS + 1; j++) begin
				case (kind)
					0: f = {f[62:0], 7'd0};
					1: f = {f[62:0], 7'($urandom_range(0, 3))};
					2: f = {f[62:0], 7'($urandom_range(0, 127))};
					default: f = {f[62:0], 7'($urandom_range(0, IN_MAX))};
				endcase
			end
			send_frame(f, 1'b0, NO_PIN);
		end

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d frames (%0d directed, the rest random with over-range and silent mixes).",
			frames_sent, n_dir);
		$display("Checked %0d bars under random stalls on both sides; %0d mismatches.",
			bars_seen, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
